FILE: rtl/rtm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rtm_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam logic [2:0] ST_UNCHANGED = 3'd0;
	localparam logic [2:0] ST_NEW       = 3'd1;
	localparam logic [2:0] ST_IMPROVED  = 3'd2;
	localparam logic [2:0] ST_DEGRADED  = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic [53:0] dest_call;
		logic [3:0]  ssid_low;
		logic [3:0]  ssid_high;
		logic [15:0] trip_time;
		logic        unreachable;
		logic [7:0]  out_port;
		logic [7:0]  kind_of_node;
		logic [47:0] alias_text;
		logic [53:0] via_call;
		logic [31:0] now_time;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  entry_index;
		logic [15:0] prior_time;
	} out_t;

	typedef struct packed {
		logic [53:0] call;
		logic [7:0]  ssid_range;
	} key_t;

	// write enables of the route store, one per field group
	typedef struct packed {
		logic main_en;
		logic stamp_en;
		logic alias_en;
		logic via_en;
	} route_wr_t;

endpackage
`default_nettype wire

FILE: rtl/route_table_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// Route table merge: folds one advertised route at a time into a table of
// TABLE_DEPTH destinations keyed by packed callsign plus SSID range.
//
// Input: present an item on route and raise start; it is taken at the edge
// where start is high and busy is low. busy stays high while the item is
// worked on. Output: result is valid for exactly one cycle with done high;
// the receiver cannot stall, so it must take the item in that cycle.
//
// Scan: the key store is scanned one entry per cycle through a single
// registered read port and one key comparator. A hit ends the scan at
// that entry; a miss reads all count entries, at most TABLE_DEPTH. The
// scan leads to the update state, whose result is registered and shown
// with done. busy falls in the cycle done is shown, so the next item may
// be taken there.
//
// Reset clears the entry count and the sequencer; table contents need no
// clearing since only entries below the count are ever read.
module route_table_merge import rtm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire in_t  route,
	output logic      done,
	output out_t      result
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_UPDATE = 3'b100
	} state_t;

	state_t           state_q;
	in_t              req_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] addr_q;
	logic             rd_vld_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             found_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      old_q;
	logic             done_q;
	out_t             result_q;

	logic             accept;
	logic             issue_en;
	logic             match;
	logic             hit;
	logic             exhausted;
	logic [15:0]      rd_time;
	key_t             req_key;
	logic             refresh;
	logic             full;
	logic             key_we;
	route_wr_t        route_wr;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] rd_addr;
	out_t             result_d;
	logic             insert;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign req_key   = '{call: req_q.dest_call,
	                     ssid_range: {req_q.ssid_low, req_q.ssid_high}};
	assign issue_en  = (addr_q != cnt_q);
	assign rd_addr   = addr_q[IDX_W-1:0];
	assign hit       = rd_vld_q && match;
	assign exhausted = !rd_vld_q && !issue_en;
	assign refresh   = (req_q.trip_time == 16'd0) && !req_q.unreachable;
	assign full      = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign insert    = (state_q == S_UPDATE) && !refresh && !found_q && !full;

	rtm_key_mem u_key_mem (
		.clk     (clk),
		.wr_en   (key_we),
		.wr_addr (wr_addr),
		.wr_key  (req_key),
		.rd_addr (rd_addr),
		.cmp_key (req_key),
		.match   (match)
	);

	rtm_route_mem u_route_mem (
		.clk     (clk),
		.wr      (route_wr),
		.wr_addr (wr_addr),
		.wr_data (req_q),
		.rd_addr (rd_addr),
		.rd_time (rd_time)
	);

	// Decide the update and the result in the update cycle.
	always_comb begin
		key_we   = 1'b0;
		route_wr = '0;
		wr_addr  = found_q ? idx_q : cnt_q[IDX_W-1:0];
		result_d = '{status: ST_UNCHANGED, entry_index: 8'd0, prior_time: 16'd0};
		if (state_q == S_UPDATE) begin
			priority if (refresh) begin
				// refresh marker: touch the stamp of a known entry only
				if (found_q) begin
					route_wr.stamp_en = 1'b1;
					result_d = '{status: ST_UNCHANGED, entry_index: 8'(idx_q),
					             prior_time: old_q};
				end
			end else if (!found_q) begin
				if (full) begin
					result_d.status = ST_FULL;
				end else begin
					key_we   = 1'b1;
					route_wr = '{main_en: 1'b1, stamp_en: 1'b1, alias_en: 1'b1,
					             via_en: 1'b1};
					result_d = '{status: ST_NEW, entry_index: 8'(cnt_q[IDX_W-1:0]),
					             prior_time: 16'd0};
				end
			end else if (req_q.trip_time == old_q) begin
				result_d = '{status: ST_UNCHANGED, entry_index: 8'(idx_q),
				             prior_time: old_q};
			end else begin
				// changed time: overwrite, keep alias and via unless given
				route_wr = '{main_en: 1'b1, stamp_en: 1'b1,
				             alias_en: (req_q.alias_text != 48'd0),
				             via_en: (req_q.via_call != 54'd0)};
				result_d = '{status: (req_q.trip_time < old_q) ? ST_IMPROVED
				                                                 : ST_DEGRADED,
				             entry_index: 8'(idx_q), prior_time: old_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			addr_q   <= '0;
			rd_vld_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			// strobe the result in the cycle after the update
			done_q <= (state_q == S_UPDATE);
			unique case (state_q)
				S_IDLE: begin
					rd_vld_q <= 1'b0;
					if (accept) begin
						addr_q  <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// issue one read per cycle, compare it the cycle after
					if (issue_en) begin
						addr_q <= addr_q + CNT_W'(1);
					end
					if (hit || exhausted) begin
						rd_vld_q <= 1'b0;
						state_q  <= S_UPDATE;
					end else begin
						rd_vld_q <= issue_en;
					end
				end
				S_UPDATE: begin
					if (insert) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers: request, scan tag, match capture, result.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= route;
		end
		rd_idx_q <= addr_q[IDX_W-1:0];
		if (state_q == S_SCAN) begin
			found_q <= hit;
			idx_q   <= hit ? rd_idx_q : '0;
			old_q   <= hit ? rd_time : 16'd0;
		end
		if (state_q == S_UPDATE) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// entry count never passes the table size
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table size");

	// a result is shown only right after an update cycle, with the block free
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q == S_UPDATE) && !busy))
		else $error("result strobe outside update");

	// a full table reports no entry and no prior time
	a_full_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_FULL) |->
			(result.entry_index == 8'd0 && result.prior_time == 16'd0))
		else $error("table full result carries data");

	// the count grows only together with a new-entry result
	a_cnt_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> (done && result.status == ST_NEW))
		else $error("entry count changed without insert");

endmodule
`default_nettype wire

FILE: rtl/rtm_key_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module rtm_key_mem import rtm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire key_t             wr_key,
	input  wire logic [IDX_W-1:0] rd_addr,
	input  wire key_t             cmp_key,
	output logic                  match
);

	key_t mem [TABLE_DEPTH];
	key_t rd_key_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_key;
		end
		rd_key_q <= mem[rd_addr];
	end

	// shared compare unit: one stored key against the request per cycle
	assign match = (rd_key_q == cmp_key);

endmodule
`default_nettype wire

FILE: rtl/rtm_route_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module rtm_route_mem import rtm_pkg::*; (
	input  wire logic             clk,
	input  wire route_wr_t        wr,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire in_t              wr_data,
	input  wire logic [IDX_W-1:0] rd_addr,
	output logic [15:0]           rd_time
);

	logic [15:0] time_mem  [TABLE_DEPTH];
	logic        unr_mem   [TABLE_DEPTH];
	logic [15:0] pk_mem    [TABLE_DEPTH];
	logic [47:0] alias_mem [TABLE_DEPTH];
	logic [53:0] via_mem   [TABLE_DEPTH];
	logic [31:0] stamp_mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.main_en) begin
			time_mem[wr_addr] <= wr_data.trip_time;
			unr_mem[wr_addr]  <= wr_data.unreachable;
			pk_mem[wr_addr]   <= {wr_data.out_port, wr_data.kind_of_node};
		end
		if (wr.stamp_en) begin
			stamp_mem[wr_addr] <= wr_data.now_time;
		end
		if (wr.alias_en) begin
			alias_mem[wr_addr] <= wr_data.alias_text;
		end
		if (wr.via_en) begin
			via_mem[wr_addr] <= wr_data.via_call;
		end
		rd_time <= time_mem[rd_addr];
	end

endmodule
`default_nettype wire

FILE: tb/sv/route_merge_check.sv
`timescale 1ns / 1ps
module route_merge_check import rtm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic busy,
	input  wire in_t  route,
	input  wire logic done,
	input  wire out_t result,
	output int        mismatches,
	output int        awaiting
);

	// Predicted table. Only key and trip time affect the result fields, so
	// the other per-entry fields are not kept.
	logic [53:0] tbl_call  [TABLE_DEPTH];
	logic [7:0]  tbl_range [TABLE_DEPTH];
	logic [15:0] tbl_time  [TABLE_DEPTH];
	int          tbl_used = 0;

	out_t expected_results [$];
	int   mismatch_count = 0;
	int   waiting_count  = 0;

	assign mismatches = mismatch_count;
	assign awaiting   = waiting_count;

	// Fold one advertisement into the predicted table and return its result.
	function automatic out_t merge_route(input in_t r);
		out_t        o;
		int          hit;
		int          i;
		logic [7:0]  rng;
		rng = {r.ssid_low, r.ssid_high};
		o   = '0;
		hit = -1;
		for (i = 0; i < tbl_used; i++) begin
			if (hit < 0 && tbl_call[i] == r.dest_call && tbl_range[i] == rng)
				hit = i;
		end
		if (r.trip_time == '0 && !r.unreachable) begin
			// refresh marker: report the match, never insert
			o.status = ST_UNCHANGED;
			if (hit >= 0) begin
				o.entry_index = hit[7:0];
				o.prior_time  = tbl_time[hit];
			end
		end else if (hit < 0) begin
			if (tbl_used >= TABLE_DEPTH) begin
				o.status = ST_FULL;
			end else begin
				tbl_call[tbl_used]  = r.dest_call;
				tbl_range[tbl_used] = rng;
				tbl_time[tbl_used]  = r.trip_time;
				o.status      = ST_NEW;
				o.entry_index = tbl_used[7:0];
				tbl_used++;
			end
		end else begin
			o.entry_index = hit[7:0];
			o.prior_time  = tbl_time[hit];
			if (r.trip_time == tbl_time[hit]) begin
				o.status = ST_UNCHANGED;
			end else begin
				o.status = (r.trip_time < tbl_time[hit]) ? ST_IMPROVED : ST_DEGRADED;
				tbl_time[hit] = r.trip_time;
			end
		end
		return o;
	endfunction

	task automatic flag_result(input string why, input out_t want, input out_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t ns: %s: want status %0d index %0d prior %0d, got status %0d index %0d prior %0d",
				$time, why, want.status, want.entry_index, want.prior_time,
				got.status, got.entry_index, got.prior_time);
	endtask

	// Take the result before the item: both can fall on one edge.
	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					flag_result("result with nothing expected", '0, result);
				end else begin
					want = expected_results.pop_front();
					if (result.status !== want.status ||
						result.entry_index !== want.entry_index ||
						result.prior_time !== want.prior_time)
						flag_result("result mismatch", want, result);
				end
			end
			if (start && !busy)
				expected_results.push_back(merge_route(route));
			waiting_count = expected_results.size();
		end
	end

endmodule

FILE: tb/sv/route_table_merge_tb.sv
`timescale 1ns / 1ps
module route_table_merge_tb;
	import rtm_pkg::*;

	localparam int POOL_SIZE     = 48;
	// longest miss scan plus margin
	localparam int SETTLE_CYCLES = TABLE_DEPTH + 40;
	// run bound: several times the slowest correct run
	localparam int TIMEOUT_NS    = 12_000_000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	in_t  route;
	out_t result;
	int   mismatches;
	int   awaiting;
	int   idle_pct;

	// Keys that come back again and again, so hits dominate the random part.
	logic [53:0] pool_call  [POOL_SIZE];
	logic [7:0]  pool_range [POOL_SIZE];

	route_table_merge i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.route  (route),
		.done   (done),
		.result (result)
	);

	route_merge_check i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.route      (route),
		.done       (done),
		.result     (result),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Bound the run; a hung block lands here.
	initial begin
		#(TIMEOUT_NS);
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [53:0] rand_call();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[53:0];
	endfunction

	// Build an advertisement for a key; the payload fields are random, with
	// alias and via left empty about a third of the time.
	function automatic in_t make_route(input logic [53:0] call, input logic [7:0] rng,
		input logic [15:0] rtt, input logic inf);
		in_t         r;
		logic [63:0] w;
		r.dest_call                = call;
		{r.ssid_low, r.ssid_high}  = rng;
		r.trip_time                = rtt;
		r.unreachable              = inf;
		r.out_port                 = 8'($urandom());
		r.kind_of_node             = 8'($urandom());
		w = {$urandom(), $urandom()};
		r.alias_text = ($urandom_range(9) < 3) ? 48'd0 : w[47:0];
		w = {$urandom(), $urandom()};
		r.via_call   = ($urandom_range(9) < 3) ? 54'd0 : w[53:0];
		r.now_time   = $urandom();
		return r;
	endfunction

	// Favor refresh markers and a narrow band of small times, so that
	// same-time, improved and degraded all turn up often on known keys.
	function automatic logic [15:0] pick_rtt();
		case ($urandom_range(9))
			0, 1, 2: return 16'd0;
			3:       return 16'hFFFF;
			4, 5, 6: return 16'($urandom_range(6, 1));
			default: return 16'($urandom());
		endcase
	endfunction

	// Present one item and hold it until the block takes it. Idle first when
	// the phase asks; now and then idle long enough to cover a whole scan.
	task automatic send_route(input in_t r);
		int gap;
		gap = 0;
		if (idle_pct > 0) begin
			if ($urandom_range(15) == 0)
				gap = $urandom_range(TABLE_DEPTH + 20);
			else
				while ($urandom_range(99) < idle_pct && gap < 40)
					gap++;
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		route <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	// Drop start and hold off until every predicted result has come back.
	// Sample on the falling edge so the checker has settled.
	task automatic drain_results();
		start <= 1'b0;
		do @(negedge clk); while (awaiting != 0);
		@(posedge clk);
	endtask

	// Random traffic: mostly pool keys, the rest fresh keys that insert or,
	// once the table is full, bounce off it.
	task automatic run_phase(input int items, input int idle, input int fresh_pct);
		int          n;
		int          k;
		logic [53:0] call;
		logic [7:0]  rng;
		idle_pct = idle;
		for (n = 0; n < items; n++) begin
			if ($urandom_range(99) < fresh_pct) begin
				call = rand_call();
				rng  = 8'($urandom());
			end else begin
				k    = $urandom_range(POOL_SIZE - 1);
				call = pool_call[k];
				rng  = pool_range[k];
			end
			send_route(make_route(call, rng, pick_rtt(), $urandom_range(7) == 0));
		end
		drain_results();
	endtask

	initial begin
		in_t r;
		int  k;
		start    = 1'b0;
		route    = '0;
		arst_n   = 1'b0;
		idle_pct = 0;

		// Pair up half the pool: same callsign, different SSID range.
		for (k = 0; k < POOL_SIZE; k++) begin
			pool_call[k]  = (k % 2 == 1 && $urandom_range(1)) ? pool_call[k - 1] : rand_call();
			pool_range[k] = 8'($urandom());
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Keys: all-ones call with full range, all-zero call
		// with zero range, zero call with inverted range, all-ones call with
		// a range that differs only from the first key.
		send_route(make_route('1, 8'hFF, 16'd0, 1'b0));          // refresh, empty table
		r = make_route('1, 8'hFF, 16'hFFFF, 1'b0);
		r.out_port     = '1;
		r.kind_of_node = '1;
		r.alias_text   = '1;
		r.via_call     = '1;
		r.now_time     = '1;
		send_route(r);                                           // insert, all ones
		r = make_route('0, 8'h00, 16'd1, 1'b0);
		r.out_port     = '0;
		r.kind_of_node = '0;
		r.alias_text   = '0;
		r.via_call     = '0;
		r.now_time     = '0;
		send_route(r);                                           // insert, all zeros
		send_route(make_route('0, 8'hF0, 16'd0, 1'b1));          // inverted range, infinity
		send_route(make_route('1, 8'h0F, 16'd1234, 1'b0));       // same call, other range
		send_route(make_route('1, 8'hFF, 16'd0, 1'b0));          // refresh a known key
		send_route(make_route('1, 8'hFF, 16'hFFFF, 1'b1));       // same time, flag differs
		r = make_route('1, 8'hFF, 16'd100, 1'b0);
		r.alias_text = '0;
		r.via_call   = '0;
		send_route(r);                                           // improve, keep alias/via
		send_route(make_route('1, 8'hFF, 16'd200, 1'b0));        // degrade
		send_route(make_route('0, 8'h00, 16'hFFFF, 1'b0));       // degrade to the top
		send_route(make_route('0, 8'h00, 16'd1, 1'b0));          // improve to the bottom
		send_route(make_route('0, 8'hF0, 16'd0, 1'b1));          // infinity again, same time
		send_route(make_route('0, 8'hF0, 16'd0, 1'b0));          // refresh with held time 0
		send_route(make_route('0, 8'hF0, 16'd5, 1'b0));          // degrade from 0
		send_route(make_route('0, 8'hF0, 16'd0, 1'b1));          // improve to 0 as infinity
		send_route(make_route('1, 8'h0F, 16'd1234, 1'b0));       // same time
		send_route(make_route(rand_call(), 8'($urandom()), 16'hFFFF, 1'b1));
		send_route(make_route(rand_call(), 8'($urandom()), 16'd0, 1'b0)); // refresh, unknown
		drain_results();

		// Random part: fill gradually, force the table full, then keep
		// hitting known keys while fresh ones are turned away.
		run_phase(500, 70, 15);
		run_phase(300, 29, 100);
		run_phase(450, 0, 20);
		run_phase(450, 29, 20);

		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && awaiting == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
